FILE: design/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

    // field widths
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned SERVER_W = 12;
    localparam int unsigned PRI_W    = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SRC_W    = 24;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // default source number used for the inter-processor interrupt
    localparam int unsigned IPI_SOURCE_DEF = 2;

    // priority meaning masked or nothing pending
    localparam logic [PRI_W-1:0] PRI_NONE = 8'hff;

    // commands
    typedef enum logic [CMD_W-1:0] {
        CMD_ACCEPT   = 3'd0,
        CMD_SET_MFRR = 3'd1,
        CMD_SET_CPPR = 3'd2,
        CMD_EOI      = 3'd3,
        CMD_DELIVER  = 3'd4
    } t_cmd;

    // status codes
    localparam logic [STATUS_W-1:0] ST_SUCCESS  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_HARD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_OWN  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBUG_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_SERVER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EOI_NOTIFY = 2'd3;

endpackage

`default_nettype wire

FILE: design/interrupt_presentation_controller_core.sv
`default_nettype none

// Interrupt presentation controller for one server: keeps the processor
// priority (cppr), the IPI priority (mfrr), one pending interrupt and a resend
// mark, and executes one command per transaction (accept, set mfrr, set cppr,
// eoi, deliver). Every transaction produces exactly one result. The command is
// decoded and the state updated in the cycle it is accepted; the result sits in
// an output register, so a new transaction can be accepted in every cycle, limited
// only by the output register being held by i_stall. The user writes configuration
// through i_cfg_we/i_cfg_index/i_cfg_data only while idle; the block does not enforce it.
module interrupt_presentation_controller_core #(
    parameter int unsigned IPI_SOURCE = ipc_pkg::IPI_SOURCE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [ipc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ipc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // command channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [ipc_pkg::CMD_W-1:0]       i_command,
    input  wire logic [ipc_pkg::SERVER_W-1:0]    i_target_server,
    input  wire logic [ipc_pkg::PRI_W-1:0]       i_priority_req,
    input  wire logic [ipc_pkg::WORD_W-1:0]      i_xirr_word,
    input  wire logic [ipc_pkg::SRC_W-1:0]       i_source_number,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [ipc_pkg::STATUS_W-1:0]         o_status,
    output logic [ipc_pkg::WORD_W-1:0]           o_xirr_value,
    output logic                                 o_reject_valid,
    output logic [ipc_pkg::SRC_W-1:0]            o_reject_source,
    output logic                                 o_resend_needed,
    output logic                                 o_eoi_notify_valid,
    output logic [ipc_pkg::SRC_W-1:0]            o_eoi_source,
    output logic                                 o_interrupt_out
);

    localparam logic [ipc_pkg::SRC_W-1:0] IPI_SRC = ipc_pkg::SRC_W'(IPI_SOURCE);

    // configuration registers
    logic                           r_enabled;
    logic                           r_debug_mode;
    logic [ipc_pkg::SERVER_W-1:0]   r_own_server;
    logic                           r_eoi_notify;

    // presentation state
    logic [ipc_pkg::PRI_W-1:0]      r_cur_pri,  n_cur_pri;
    logic [ipc_pkg::PRI_W-1:0]      r_ipi_pri,  n_ipi_pri;
    logic [ipc_pkg::PRI_W-1:0]      r_pend_pri, n_pend_pri;
    logic [ipc_pkg::SRC_W-1:0]      r_pend_src, n_pend_src;
    logic                           r_resend,   n_resend;

    // result register
    logic                           r_valid;
    logic [ipc_pkg::STATUS_W-1:0]   r_status,   n_status;
    logic [ipc_pkg::WORD_W-1:0]     r_xirr,     n_xirr;
    logic                           r_rej_v,    n_rej_v;
    logic [ipc_pkg::SRC_W-1:0]      r_rej_src,  n_rej_src;
    logic                           r_resend_o, n_resend_o;
    logic                           r_eoi_v,    n_eoi_v;
    logic [ipc_pkg::SRC_W-1:0]      r_eoi_src,  n_eoi_src;
    logic                           r_irq,      n_irq;

    logic                           w_accept;
    logic [ipc_pkg::SRC_W-1:0]      w_rej;
    logic                           w_skip_debug;
    logic [ipc_pkg::PRI_W-1:0]      w_low_cppr;
    logic                           w_ipi_present;
    logic [ipc_pkg::SRC_W-1:0]      w_eoi_irq;

    // handshake: stall only while the result register is full and held
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b0;
            r_debug_mode <= 1'b0;
            r_own_server <= '0;
            r_eoi_notify <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ipc_pkg::CFG_ENABLED:    r_enabled    <= i_cfg_data[0];
                ipc_pkg::CFG_DEBUG_MODE: r_debug_mode <= i_cfg_data[0];
                ipc_pkg::CFG_OWN_SERVER: r_own_server <= i_cfg_data[ipc_pkg::SERVER_W-1:0];
                ipc_pkg::CFG_EOI_NOTIFY: r_eoi_notify <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // lowering priority: new cppr comes from the eoi word or the request
    assign w_low_cppr = (i_command == ipc_pkg::CMD_EOI) ?
                        i_xirr_word[ipc_pkg::WORD_W-1:ipc_pkg::SRC_W] : i_priority_req;
    assign w_ipi_present = (r_ipi_pri < w_low_cppr) && (r_ipi_pri <= r_pend_pri);
    assign w_eoi_irq     = i_xirr_word[ipc_pkg::SRC_W-1:0];

    // command execution
    always_comb begin
        n_cur_pri    = r_cur_pri;
        n_ipi_pri    = r_ipi_pri;
        n_pend_pri   = r_pend_pri;
        n_pend_src   = r_pend_src;
        n_resend     = r_resend;
        n_status     = ipc_pkg::ST_SUCCESS;
        n_xirr       = '0;
        w_rej        = '0;
        n_resend_o   = 1'b0;
        n_eoi_v      = 1'b0;
        n_eoi_src    = '0;
        w_skip_debug = 1'b0;

        if (!r_enabled) begin
            n_status = ipc_pkg::ST_TOO_HARD;
        end else begin
            unique case (i_command)
                ipc_pkg::CMD_ACCEPT: begin
                    n_xirr = {r_cur_pri, r_pend_src};
                    if (r_pend_src != '0) begin
                        n_cur_pri  = r_pend_pri;
                        n_pend_pri = ipc_pkg::PRI_NONE;
                        n_pend_src = '0;
                    end
                end
                ipc_pkg::CMD_SET_MFRR: begin
                    if (i_target_server != r_own_server) begin
                        n_status     = ipc_pkg::ST_NOT_OWN;
                        w_skip_debug = 1'b1;
                    end else begin
                        n_ipi_pri = i_priority_req;
                        if (i_priority_req < r_cur_pri && i_priority_req <= r_pend_pri) begin
                            w_rej      = r_pend_src;
                            n_pend_pri = i_priority_req;
                            n_pend_src = IPI_SRC;
                        end
                        if (i_priority_req > r_ipi_pri) begin
                            n_resend_o = r_resend;
                            n_resend   = 1'b0;
                        end
                    end
                end
                ipc_pkg::CMD_SET_CPPR: begin
                    if (i_priority_req > r_cur_pri) begin
                        n_cur_pri = w_low_cppr;
                        if (w_ipi_present) begin
                            n_pend_pri = r_ipi_pri;
                            n_pend_src = IPI_SRC;
                        end
                        n_resend_o = r_resend;
                        n_resend   = 1'b0;
                    end else if (i_priority_req == r_cur_pri) begin
                        w_skip_debug = 1'b1;
                    end else begin
                        n_cur_pri = i_priority_req;
                        if (i_priority_req <= r_pend_pri) begin
                            w_rej      = r_pend_src;
                            n_pend_src = '0;
                            n_pend_pri = ipc_pkg::PRI_NONE;
                        end
                    end
                end
                ipc_pkg::CMD_EOI: begin
                    n_cur_pri = w_low_cppr;
                    if (w_ipi_present) begin
                        n_pend_pri = r_ipi_pri;
                        n_pend_src = IPI_SRC;
                    end
                    n_resend_o = r_resend;
                    n_resend   = 1'b0;
                    if (w_eoi_irq != '0 && w_eoi_irq != IPI_SRC && r_eoi_notify) begin
                        n_eoi_v   = 1'b1;
                        n_eoi_src = w_eoi_irq;
                    end
                end
                ipc_pkg::CMD_DELIVER: begin
                    if (i_source_number != '0) begin
                        if (i_priority_req < r_cur_pri && i_priority_req < r_ipi_pri &&
                            i_priority_req < r_pend_pri) begin
                            w_rej      = r_pend_src;
                            n_pend_src = i_source_number;
                            n_pend_pri = i_priority_req;
                        end else begin
                            n_resend = 1'b1;
                        end
                    end
                end
                default: begin
                    n_status = ipc_pkg::ST_TOO_HARD;
                end
            endcase
        end

        // only displaced external sources are reported
        n_rej_v   = (w_rej != '0) && (w_rej != IPI_SRC);
        n_rej_src = n_rej_v ? w_rej : '0;

        // reports and debug mode defer the access
        if (n_status == ipc_pkg::ST_SUCCESS && (n_rej_v || n_resend_o || n_eoi_v)) begin
            n_status = ipc_pkg::ST_TOO_HARD;
        end
        if (n_status == ipc_pkg::ST_SUCCESS && r_debug_mode && !w_skip_debug) begin
            n_status = ipc_pkg::ST_TOO_HARD;
        end

        // interrupt line from the updated state
        n_irq = (n_pend_src != '0) && (n_pend_pri < n_cur_pri);
    end

    // state update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_pri  <= '0;
            r_ipi_pri  <= ipc_pkg::PRI_NONE;
            r_pend_pri <= ipc_pkg::PRI_NONE;
            r_pend_src <= '0;
            r_resend   <= 1'b0;
        end else if (w_accept) begin
            r_cur_pri  <= n_cur_pri;
            r_ipi_pri  <= n_ipi_pri;
            r_pend_pri <= n_pend_pri;
            r_pend_src <= n_pend_src;
            r_resend   <= n_resend;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_xirr     <= n_xirr;
            r_rej_v    <= n_rej_v;
            r_rej_src  <= n_rej_src;
            r_resend_o <= n_resend_o;
            r_eoi_v    <= n_eoi_v;
            r_eoi_src  <= n_eoi_src;
            r_irq      <= n_irq;
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_xirr_value       = r_xirr;
    assign o_reject_valid     = r_rej_v;
    assign o_reject_source    = r_rej_src;
    assign o_resend_needed    = r_resend_o;
    assign o_eoi_notify_valid = r_eoi_v;
    assign o_eoi_source       = r_eoi_src;
    assign o_interrupt_out    = r_irq;

`ifndef NO_ASSERTIONS
    // an accepted transaction always shows a result next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted transaction produced no result");

    // any report defers the access
    a_report_too_hard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_reject_valid || o_resend_needed || o_eoi_notify_valid))
        |-> (o_status == ipc_pkg::ST_TOO_HARD))
        else $error("report without too_hard status");

    // disabled controller answers too_hard and leaves the state alone
    a_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_enabled) |=>
        (o_status == ipc_pkg::ST_TOO_HARD && $stable(r_cur_pri) && $stable(r_pend_src)))
        else $error("disabled controller changed behavior");

    // reported sources are never zero and never the ipi source
    a_report_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reject_valid) |-> (o_reject_source != '0 && o_reject_source != IPI_SRC))
        else $error("bad rejected source");
`endif

endmodule

`default_nettype wire

FILE: tb/presentation_checker.sv
module presentation_checker
    import ipc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration writes seen by the block
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // command channel
    input  wire logic                  i_cmd_valid,
    input  wire logic                  i_cmd_stall,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [SERVER_W-1:0]   i_target_server,
    input  wire logic [PRI_W-1:0]      i_priority_req,
    input  wire logic [WORD_W-1:0]     i_xirr_word,
    input  wire logic [SRC_W-1:0]      i_source_number,
    // result channel
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_stall,
    input  wire logic [STATUS_W-1:0]   i_status,
    input  wire logic [WORD_W-1:0]     i_xirr_value,
    input  wire logic                  i_reject_valid,
    input  wire logic [SRC_W-1:0]      i_reject_source,
    input  wire logic                  i_resend_needed,
    input  wire logic                  i_eoi_notify_valid,
    input  wire logic [SRC_W-1:0]      i_eoi_source,
    input  wire logic                  i_interrupt_out,
    // verdict data for the top
    output int                         o_mismatches,
    output int                         o_outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SRC_W-1:0] IPI_SRC = SRC_W'(IPI_SOURCE_DEF);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   xirr;
        logic                rej_v;
        logic [SRC_W-1:0]    rej_src;
        logic                resend;
        logic                eoi_v;
        logic [SRC_W-1:0]    eoi_src;
        logic                irq;
    } t_presentation;

    // configuration copy
    logic                cfg_en;
    logic                cfg_dbg;
    logic [SERVER_W-1:0] cfg_own;
    logic                cfg_ntf;

    // presentation state copy
    logic [PRI_W-1:0] cppr;
    logic [PRI_W-1:0] mfrr;
    logic [PRI_W-1:0] pend_pri;
    logic [SRC_W-1:0] pend_src;
    logic             resend_mark;

    t_presentation expected_replies[$];
    t_presentation want;
    t_presentation got;
    int            mismatches;

    // lower the processor priority, possibly presenting the ipi; returns the old mark
    function automatic logic drop_priority(input logic [PRI_W-1:0] next_pri);
        logic old_mark;
        cppr = next_pri;
        if (mfrr < next_pri && mfrr <= pend_pri) begin
            pend_pri = mfrr;
            pend_src = IPI_SRC;
        end
        old_mark = resend_mark;
        resend_mark = 1'b0;
        return old_mark;
    endfunction

    // expected result of one command, updating the state copy
    function automatic t_presentation present_command(
        input logic [CMD_W-1:0]    cmd,
        input logic [SERVER_W-1:0] srv,
        input logic [PRI_W-1:0]    pri,
        input logic [WORD_W-1:0]   word,
        input logic [SRC_W-1:0]    src
    );
        t_presentation    r;
        logic [SRC_W-1:0] rej;
        logic [PRI_W-1:0] old_mfrr;
        logic             skip_dbg;
        r = '0;
        rej = '0;
        skip_dbg = 1'b0;
        if (!cfg_en || cmd > CMD_DELIVER) begin
            r.status = ST_TOO_HARD;
        end else begin
            case (cmd)
                CMD_ACCEPT: begin
                    r.xirr = {cppr, pend_src};
                    if (pend_src != '0) begin
                        cppr = pend_pri;
                        pend_pri = PRI_NONE;
                        pend_src = '0;
                    end
                end
                CMD_SET_MFRR: begin
                    if (srv != cfg_own) begin
                        r.status = ST_NOT_OWN;
                        skip_dbg = 1'b1;
                    end else begin
                        old_mfrr = mfrr;
                        mfrr = pri;
                        if (pri < cppr && pri <= pend_pri) begin
                            rej = pend_src;
                            pend_pri = pri;
                            pend_src = IPI_SRC;
                        end
                        if (pri > old_mfrr) begin
                            r.resend = resend_mark;
                            resend_mark = 1'b0;
                        end
                    end
                end
                CMD_SET_CPPR: begin
                    if (pri > cppr) begin
                        r.resend = drop_priority(pri);
                    end else if (pri == cppr) begin
                        skip_dbg = 1'b1;
                    end else begin
                        cppr = pri;
                        if (pri <= pend_pri) begin
                            rej = pend_src;
                            pend_src = '0;
                            pend_pri = PRI_NONE;
                        end
                    end
                end
                CMD_EOI: begin
                    r.resend = drop_priority(word[31:24]);
                    if (word[23:0] != '0 && word[23:0] != IPI_SRC && cfg_ntf) begin
                        r.eoi_v = 1'b1;
                        r.eoi_src = word[23:0];
                    end
                end
                default: begin
                    // deliver of an external source; source zero is ignored
                    if (src != '0) begin
                        if (pri < cppr && pri < mfrr && pri < pend_pri) begin
                            rej = pend_src;
                            pend_src = src;
                            pend_pri = pri;
                        end else begin
                            resend_mark = 1'b1;
                        end
                    end
                end
            endcase
        end
        // the ipi is never reported as rejected
        if (rej != '0 && rej != IPI_SRC) begin
            r.rej_v = 1'b1;
            r.rej_src = rej;
        end
        if (r.status == ST_SUCCESS && (r.rej_v || r.resend || r.eoi_v))
            r.status = ST_TOO_HARD;
        if (r.status == ST_SUCCESS && cfg_dbg && !skip_dbg)
            r.status = ST_TOO_HARD;
        r.irq = (pend_src != '0) && (pend_pri < cppr);
        return r;
    endfunction

    // track configuration, predict on each command, compare on each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_en = 1'b0;
            cfg_dbg = 1'b0;
            cfg_own = '0;
            cfg_ntf = 1'b0;
            cppr = '0;
            mfrr = PRI_NONE;
            pend_pri = PRI_NONE;
            pend_src = '0;
            resend_mark = 1'b0;
            expected_replies.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENABLED:    cfg_en = i_cfg_data[0];
                    CFG_DEBUG_MODE: cfg_dbg = i_cfg_data[0];
                    CFG_OWN_SERVER: cfg_own = i_cfg_data[SERVER_W-1:0];
                    CFG_EOI_NOTIFY: cfg_ntf = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                expected_replies.push_back(present_command(i_command, i_target_server,
                    i_priority_req, i_xirr_word, i_source_number));
            end
            if (i_res_valid && !i_res_stall) begin
                got = {i_status, i_xirr_value, i_reject_valid, i_reject_source,
                       i_resend_needed, i_eoi_notify_valid, i_eoi_source, i_interrupt_out};
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with nothing expected", $realtime);
                end else begin
                    want = expected_replies.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch (expected / actual)", $realtime);
                            $display("  status %0d / %0d  xirr %h / %h  irq %b / %b",
                                     want.status, got.status, want.xirr, got.xirr,
                                     want.irq, got.irq);
                            $display("  reject %b %h / %b %h  resend %b / %b",
                                     want.rej_v, want.rej_src, got.rej_v, got.rej_src,
                                     want.resend, got.resend);
                            $display("  eoi %b %h / %b %h",
                                     want.eoi_v, want.eoi_src, got.eoi_v, got.eoi_src);
                        end
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_outstanding <= expected_replies.size();
    end

endmodule

FILE: tb/tb_interrupt_presentation_controller_core.sv
module tb_interrupt_presentation_controller_core;

    import ipc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES  = 6;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
    localparam logic [SRC_W-1:0] IPI_SRC = SRC_W'(IPI_SOURCE_DEF);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [CMD_W-1:0]      i_command;
    logic [SERVER_W-1:0]   i_target_server;
    logic [PRI_W-1:0]      i_priority_req;
    logic [WORD_W-1:0]     i_xirr_word;
    logic [SRC_W-1:0]      i_source_number;
    logic                  o_valid;
    logic                  i_stall;
    logic [STATUS_W-1:0]   o_status;
    logic [WORD_W-1:0]     o_xirr_value;
    logic                  o_reject_valid;
    logic [SRC_W-1:0]      o_reject_source;
    logic                  o_resend_needed;
    logic                  o_eoi_notify_valid;
    logic [SRC_W-1:0]      o_eoi_source;
    logic                  o_interrupt_out;

    int                  mismatches;
    int                  outstanding;
    int                  cycles;
    logic [SERVER_W-1:0] own_server;
    logic                rx_hold_req;
    logic                rx_hold_done;

    interrupt_presentation_controller_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_target_server    (i_target_server),
        .i_priority_req     (i_priority_req),
        .i_xirr_word        (i_xirr_word),
        .i_source_number    (i_source_number),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_xirr_value       (o_xirr_value),
        .o_reject_valid     (o_reject_valid),
        .o_reject_source    (o_reject_source),
        .o_resend_needed    (o_resend_needed),
        .o_eoi_notify_valid (o_eoi_notify_valid),
        .o_eoi_source       (o_eoi_source),
        .o_interrupt_out    (o_interrupt_out)
    );

    presentation_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_cmd_valid        (i_valid),
        .i_cmd_stall        (o_stall),
        .i_command          (i_command),
        .i_target_server    (i_target_server),
        .i_priority_req     (i_priority_req),
        .i_xirr_word        (i_xirr_word),
        .i_source_number    (i_source_number),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_status           (o_status),
        .i_xirr_value       (o_xirr_value),
        .i_reject_valid     (o_reject_valid),
        .i_reject_source    (o_reject_source),
        .i_resend_needed    (o_resend_needed),
        .i_eoi_notify_valid (o_eoi_notify_valid),
        .i_eoi_source       (o_eoi_source),
        .i_interrupt_out    (o_interrupt_out),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_interrupt_presentation_controller_core failed");
            $finish;
        end
    end

    // result side back-pressure, with one long hold on request
    initial begin : rx_drive
        int len;
        int r;
        logic holding;
        i_stall = 1'b0;
        rx_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            holding = rx_hold_req && !rx_hold_done;
            r = $urandom_range(0, 99);
            if (holding) begin
                i_stall <= 1'b1;
                len = 200;
            end else if (r < 35) begin
                i_stall <= 1'b0;
                len = $urandom_range(1, 12);
            end else if (r < 45) begin
                i_stall <= 1'b0;
                len = $urandom_range(30, 80);
            end else if (r < 85) begin
                i_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end else if (r < 97) begin
                i_stall <= 1'b1;
                len = $urandom_range(4, 15);
            end else begin
                i_stall <= 1'b1;
                len = $urandom_range(20, 60);
            end
            repeat (len - 1) @(negedge i_clk);
            if (holding)
                rx_hold_done = 1'b1;
        end
    end

    function automatic logic [PRI_W-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PRI_NONE;
            2, 3, 4: return PRI_W'($urandom_range(0, 7) << 5);
            default: return PRI_W'($urandom);
        endcase
    endfunction

    function automatic logic [SRC_W-1:0] pick_source();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return IPI_SRC;
            2, 3, 4: return SRC_W'($urandom_range(1, 15));
            5:       return '1;
            default: return SRC_W'($urandom);
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return CMD_ACCEPT;
        if (r < 35) return CMD_SET_MFRR;
        if (r < 55) return CMD_SET_CPPR;
        if (r < 75) return CMD_EOI;
        if (r < 97) return CMD_DELIVER;
        return CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
    endfunction

    // offer one command transaction and wait until it is taken
    task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [SERVER_W-1:0] srv,
                                 input logic [PRI_W-1:0] pri, input logic [WORD_W-1:0] word,
                                 input logic [SRC_W-1:0] src);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_command <= cmd;
        i_target_server <= srv;
        i_priority_req <= pri;
        i_xirr_word <= word;
        i_source_number <= src;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // idle cycles on the command side, mostly none
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(5, 30);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic offer_random(input logic back_to_back);
        logic [SERVER_W-1:0] srv;
        if (!back_to_back)
            sender_gap();
        srv = ($urandom_range(0, 3) != 0) ? own_server : SERVER_W'($urandom);
        offer_command(pick_command(), srv, pick_priority(),
                      {pick_priority(), pick_source()}, pick_source());
    endtask

    // stop offering and wait for every expected result
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // write all four registers on consecutive cycles
    task automatic set_config(input logic en, input logic dbg,
                              input logic [SERVER_W-1:0] srv, input logic ntf);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_ENABLED;
        i_cfg_data <= CFG_DATA_W'(en);
        @(negedge i_clk);
        i_cfg_index <= CFG_DEBUG_MODE;
        i_cfg_data <= CFG_DATA_W'(dbg);
        @(negedge i_clk);
        i_cfg_index <= CFG_OWN_SERVER;
        i_cfg_data <= CFG_DATA_W'(srv);
        @(negedge i_clk);
        i_cfg_index <= CFG_EOI_NOTIFY;
        i_cfg_data <= CFG_DATA_W'(ntf);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        own_server = srv;
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int   phase_items[NUM_PHASES] = '{400, 200, 60, 400, 300, 140};
        logic phase_en[NUM_PHASES]    = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        logic phase_dbg[NUM_PHASES]   = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
        logic phase_ntf[NUM_PHASES]   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        logic [SERVER_W-1:0] srv;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_command = CMD_ACCEPT;
        i_target_server = '0;
        i_priority_req = '0;
        i_xirr_word = '0;
        i_source_number = '0;
        own_server = '0;
        rx_hold_req = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset: everything deferred
        offer_command(CMD_ACCEPT, '0, '0, '0, '0);
        offer_command(CMD_DELIVER, '0, 8'h10, '0, 24'h000123);
        wait_drain();

        set_config(1'b1, 1'b0, 12'd5, 1'b1);
        // nothing pending, foreign server, ipi presentation and accept
        offer_command(CMD_ACCEPT, '0, '0, '0, '0);
        offer_command(CMD_SET_MFRR, '1, 8'h80, '0, '0);
        offer_command(CMD_SET_MFRR, 12'd5, 8'h80, '0, '0);
        offer_command(CMD_SET_CPPR, '0, PRI_NONE, '0, '0);
        offer_command(CMD_ACCEPT, '0, '0, '0, '0);
        offer_command(CMD_EOI, '0, '0, {PRI_NONE, IPI_SRC}, '0);
        offer_command(CMD_SET_MFRR, 12'd5, PRI_NONE, '0, '0);
        // deliver of source zero, displacing the ipi, and a held-back deliver
        offer_command(CMD_DELIVER, '0, '0, '0, '0);
        offer_command(CMD_DELIVER, '0, '0, '0, '1);
        offer_command(CMD_DELIVER, '0, 8'h40, '0, 24'h123456);
        // cppr unchanged, raised with reject, lowered with resend
        offer_command(CMD_SET_CPPR, '0, PRI_NONE, '0, '0);
        offer_command(CMD_SET_CPPR, '0, '0, '0, '0);
        offer_command(CMD_SET_CPPR, '0, PRI_NONE, '0, '0);
        // reported eoi, eoi of source zero, unknown command
        offer_command(CMD_EOI, '0, '0, 32'h00abcdef, '0);
        offer_command(CMD_EOI, '0, '0, {PRI_NONE, 24'h0}, '0);
        offer_command(CMD_UNKNOWN_HI, '1, '1, '1, '1);
        offer_command(CMD_ACCEPT, '0, '0, '0, '0);
        offer_command(CMD_SET_MFRR, 12'd5, '0, '0, '0);
        offer_command(CMD_DELIVER, '0, '0, '0, 24'h000001);
        wait_drain();

        // debug mode: foreign server and unchanged cppr keep their status
        set_config(1'b1, 1'b1, '1, 1'b0);
        offer_command(CMD_SET_MFRR, 12'd7, 8'h10, '0, '0);
        offer_command(CMD_SET_CPPR, '0, PRI_NONE, '0, '0);
        offer_command(CMD_EOI, '0, '0, 32'hffabcdef, '0);
        offer_command(CMD_ACCEPT, '0, '0, '0, '0);
        wait_drain();

        // random phases over several register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 0) srv = '0;
            else if (p == 1) srv = '1;
            else srv = SERVER_W'($urandom);
            set_config(phase_en[p], phase_dbg[p], srv, phase_ntf[p]);
            for (int k = 0; k < phase_items[p]; k++) begin
                if (p == 0 && k == 100) begin
                    // long result hold while commands keep coming
                    rx_hold_req = 1'b1;
                    while (!rx_hold_done) offer_random(1'b1);
                end
                if (p == 0 && k == 200)
                    wait_drain();
                offer_random(1'b0);
            end
            wait_drain();
        end

        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_interrupt_presentation_controller_core passed");
        else
            $display("tb_interrupt_presentation_controller_core failed");
        $finish;
    end

endmodule

FILE: interrupt_presentation_controller_core.f
design/ipc_pkg.sv
design/interrupt_presentation_controller_core.sv
tb/presentation_checker.sv
tb/tb_interrupt_presentation_controller_core.sv
